// ----- rtl/core/bta_pkg.sv -----
// shared types, constants and command/status structs of the buddy block allocator
package bta_pkg;

  localparam int POOL_LOG2 = 20;
  localparam int MIN_LOG2 = 7;
  localparam int TREE_LEVELS = 14;
  localparam int DEEP_LVL = TREE_LEVELS - 1;
  localparam int NODE_W = 14;
  localparam int NODE_DEPTH = 1 << NODE_W;
  localparam int IDX_W = 13;
  localparam int LVL_W = 4;
  localparam int SH_W = 5;
  localparam int OFF_W = 20;
  localparam int SIZE_W = 22;
  localparam int FOFF_W = 21;
  localparam int STAT_W = 3;
  localparam int IN_W = 48;
  localparam int OUT_W = 32;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_ZERO     = 3'd1,
    ST_BIG      = 3'd2,
    ST_FULL     = 3'd3,
    ST_RANGE    = 3'd4,
    ST_NOTALLOC = 3'd5
  } bta_status_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_SELF_RD, S_SELF_EV, S_ANC_RD, S_ANC_EV,
    S_DESC_RD, S_DESC_EV, S_MARK, S_FREE_RD, S_FREE_EV, S_FIN
  } bta_state_t;

  typedef enum logic [1:0] {RD_NODE, RD_PARENT, RD_DESC, RD_FREE} bta_rd_sel_t;

  typedef struct packed {
    logic        clr_step;
    logic        load;
    logic        a_init;
    logic        a_next;
    logic        anc_init;
    logic        anc_step;
    logic        desc_init;
    logic        desc_step;
    logic        f_init;
    logic        f_next;
    bta_rd_sel_t rd_sel;
    logic        mark_set;
    logic        mark_clr;
    logic        res_set;
    bta_status_t res_status;
    logic        res_free;
    logic        out_load;
  } bta_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_free;
    logic size_zero;
    logic size_big;
    logic off_big;
    logic rmark;
    logic node_root;
    logic cur_root;
    logic idx_last;
    logic lvl_deep;
    logic desc_done;
    logic f_aligned;
    logic out_busy;
  } bta_stat_t;

endpackage

// ----- rtl/core/bta_ctrl.sv -----
// sequencing state machine of the buddy block allocator
module bta_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  bta_pkg::bta_stat_t st,
  output bta_pkg::bta_cmd_t  cmd
);
  import bta_pkg::*;

  bta_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd = '0;
    cmd.rd_sel = RD_NODE;
    cmd.res_status = ST_OK;
    state_nxt = state_r;
    in_tready = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (st.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (st.is_free) begin
          if (st.off_big) begin
            cmd.res_set = 1'b1;
            cmd.res_status = ST_RANGE;
            state_nxt = S_FIN;
          end else begin
            cmd.f_init = 1'b1;
            state_nxt = S_FREE_RD;
          end
        end else if (st.size_zero) begin
          cmd.res_set = 1'b1;
          cmd.res_status = ST_ZERO;
          state_nxt = S_FIN;
        end else if (st.size_big) begin
          cmd.res_set = 1'b1;
          cmd.res_status = ST_BIG;
          state_nxt = S_FIN;
        end else begin
          cmd.a_init = 1'b1;
          state_nxt = S_SELF_RD;
        end
      end
      S_SELF_RD: begin
        cmd.rd_sel = RD_NODE;
        state_nxt = S_SELF_EV;
      end
      S_SELF_EV, S_ANC_EV, S_DESC_EV: begin
        if (st.rmark) begin
          if (st.idx_last) begin
            cmd.res_set = 1'b1;
            cmd.res_status = ST_FULL;
            state_nxt = S_FIN;
          end else begin
            cmd.a_next = 1'b1;
            state_nxt = S_SELF_RD;
          end
        end else if (state_r == S_DESC_EV) begin
          if (st.desc_done) begin
            state_nxt = S_MARK;
          end else begin
            cmd.desc_step = 1'b1;
            state_nxt = S_DESC_RD;
          end
        end else if ((state_r == S_SELF_EV && st.node_root) ||
                     (state_r == S_ANC_EV && st.cur_root)) begin
          if (st.lvl_deep) begin
            state_nxt = S_MARK;
          end else begin
            cmd.desc_init = 1'b1;
            state_nxt = S_DESC_RD;
          end
        end else if (state_r == S_SELF_EV) begin
          cmd.anc_init = 1'b1;
          state_nxt = S_ANC_RD;
        end else begin
          state_nxt = S_ANC_RD;
        end
      end
      S_ANC_RD: begin
        cmd.rd_sel = RD_PARENT;
        cmd.anc_step = 1'b1;
        state_nxt = S_ANC_EV;
      end
      S_DESC_RD: begin
        cmd.rd_sel = RD_DESC;
        state_nxt = S_DESC_EV;
      end
      S_MARK: begin
        cmd.mark_set = 1'b1;
        cmd.res_set = 1'b1;
        cmd.res_status = ST_OK;
        state_nxt = S_FIN;
      end
      S_FREE_RD: begin
        cmd.rd_sel = RD_FREE;
        if (st.f_aligned) begin
          state_nxt = S_FREE_EV;
        end else if (st.lvl_deep) begin
          cmd.res_set = 1'b1;
          cmd.res_status = ST_NOTALLOC;
          state_nxt = S_FIN;
        end else begin
          cmd.f_next = 1'b1;
        end
      end
      S_FREE_EV: begin
        if (st.rmark) begin
          cmd.mark_clr = 1'b1;
          cmd.res_set = 1'b1;
          cmd.res_free = 1'b1;
          cmd.res_status = ST_OK;
          state_nxt = S_FIN;
        end else if (st.lvl_deep) begin
          cmd.res_set = 1'b1;
          cmd.res_status = ST_NOTALLOC;
          state_nxt = S_FIN;
        end else begin
          cmd.f_next = 1'b1;
          state_nxt = S_FREE_RD;
        end
      end
      S_FIN: begin
        if (!st.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> state_r == S_IDLE)
    else $error("transaction taken outside idle");
  a_mark_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.mark_set && cmd.mark_clr))
    else $error("set and clear in one cycle");
  a_fin_follows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_set |=> state_r == S_FIN)
    else $error("result not followed by finish");

endmodule

// ----- rtl/core/bta_dpath.sv -----
// mark store, search counters and result registers of the buddy block allocator
module bta_dpath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  bta_pkg::bta_cmd_t            cmd,
  output bta_pkg::bta_stat_t           st,
  input  logic [bta_pkg::IN_W-1:0]     in_tdata,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [bta_pkg::OUT_W-1:0]    out_tdata
);
  import bta_pkg::*;

  logic                 mem [0:NODE_DEPTH-1];
  logic                 rdata_r;
  logic [NODE_W-1:0]    clr_r;
  logic                 is_free_r;
  logic [SIZE_W-1:0]    size_r;
  logic [FOFF_W-1:0]    foff_r;
  logic [LVL_W-1:0]     lvl_r;
  logic [IDX_W-1:0]     idx_r;
  logic [NODE_W-1:0]    node_r, cur_r, dn_r, dfirst_r, dlast_r;
  logic [LVL_W-1:0]     dlev_r;
  bta_status_t          res_stat_r;
  logic [OFF_W-1:0]     res_off_r;
  logic [LVL_W-1:0]     res_lvl_r;
  logic                 out_valid_r;
  bta_status_t          out_stat_r;
  logic [OFF_W-1:0]     out_off_r;
  logic [LVL_W-1:0]     out_lvl_r;

  logic [SIZE_W-1:0]    need;
  logic [SH_W-1:0]      kbits;
  logic [SH_W-1:0]      sh;
  logic [NODE_W-1:0]    lvl_base, lvl_last, parent, fnode, raddr, waddr, nfirst;
  logic [OFF_W-1:0]     a_off, f_mask;
  logic                 we, wdata;

  always_comb begin
    need = (size_r < SIZE_W'(1 << MIN_LOG2)) ? SIZE_W'(1 << MIN_LOG2) : size_r;
    kbits = '0;
    for (int i = 0; i < SIZE_W; i++) begin
      if ({1'b0, need} > ((SIZE_W+1)'(1) << i)) kbits = SH_W'(i + 1);
    end
  end

  assign sh       = SH_W'(POOL_LOG2) - {1'b0, lvl_r};
  assign lvl_base = (NODE_W'(1) << lvl_r) - NODE_W'(1);
  assign lvl_last = lvl_base;
  assign parent   = (cur_r - NODE_W'(1)) >> 1;
  assign a_off    = {{(OFF_W-IDX_W){1'b0}}, idx_r} << sh;
  assign f_mask   = (OFF_W'(1) << sh) - OFF_W'(1);
  assign fnode    = lvl_base + NODE_W'(foff_r[OFF_W-1:0] >> sh);
  assign nfirst   = {dfirst_r[NODE_W-2:0], 1'b1};

  always_comb begin
    case (cmd.rd_sel)
      RD_NODE:   raddr = node_r;
      RD_PARENT: raddr = parent;
      RD_DESC:   raddr = dn_r;
      RD_FREE:   raddr = fnode;
      default:   raddr = node_r;
    endcase
    we = cmd.clr_step | cmd.mark_set | cmd.mark_clr;
    wdata = cmd.mark_set;
    if (cmd.clr_step) waddr = clr_r;
    else if (cmd.mark_set) waddr = node_r;
    else waddr = fnode;
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_step) clr_r <= clr_r + NODE_W'(1);
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      is_free_r <= in_tdata[0];
      size_r <= in_tdata[SIZE_W:1];
      foff_r <= in_tdata[SIZE_W+FOFF_W:SIZE_W+1];
    end
    if (cmd.a_init) begin
      lvl_r <= LVL_W'(POOL_LOG2 - kbits);
      idx_r <= '0;
      node_r <= (NODE_W'(1) << LVL_W'(POOL_LOG2 - kbits)) - NODE_W'(1);
    end else if (cmd.a_next) begin
      idx_r <= idx_r + IDX_W'(1);
      node_r <= node_r + NODE_W'(1);
    end else if (cmd.f_init) begin
      lvl_r <= '0;
    end else if (cmd.f_next) begin
      lvl_r <= lvl_r + LVL_W'(1);
    end
    if (cmd.anc_init) cur_r <= node_r;
    else if (cmd.anc_step) cur_r <= parent;
    if (cmd.desc_init) begin
      dn_r <= {node_r[NODE_W-2:0], 1'b1};
      dfirst_r <= {node_r[NODE_W-2:0], 1'b1};
      dlast_r <= {node_r[NODE_W-2:0], 1'b0} + NODE_W'(2);
      dlev_r <= lvl_r + LVL_W'(1);
    end else if (cmd.desc_step) begin
      if (dn_r == dlast_r) begin
        dn_r <= nfirst;
        dfirst_r <= nfirst;
        dlast_r <= {dlast_r[NODE_W-2:0], 1'b0} + NODE_W'(2);
        dlev_r <= dlev_r + LVL_W'(1);
      end else begin
        dn_r <= dn_r + NODE_W'(1);
      end
    end
    if (cmd.res_set) begin
      res_stat_r <= cmd.res_status;
      if (cmd.res_status != ST_OK) begin
        res_off_r <= '0;
        res_lvl_r <= '0;
      end else begin
        res_off_r <= cmd.res_free ? foff_r[OFF_W-1:0] : a_off;
        res_lvl_r <= lvl_r;
      end
    end
    if (cmd.out_load) begin
      out_stat_r <= res_stat_r;
      out_off_r <= res_off_r;
      out_lvl_r <= res_lvl_r;
    end
  end

  always_comb begin
    st.clr_last  = (clr_r == {NODE_W{1'b1}});
    st.is_free   = is_free_r;
    st.size_zero = (size_r == '0);
    st.size_big  = (size_r > SIZE_W'(1 << POOL_LOG2));
    st.off_big   = foff_r[FOFF_W-1];
    st.rmark     = rdata_r;
    st.node_root = (node_r == '0);
    st.cur_root  = (cur_r == '0);
    st.idx_last  = ({1'b0, idx_r} == lvl_last);
    st.lvl_deep  = (lvl_r == LVL_W'(DEEP_LVL));
    st.desc_done = (dn_r == dlast_r) && (dlev_r == LVL_W'(DEEP_LVL));
    st.f_aligned = ((foff_r[OFF_W-1:0] & f_mask) == '0);
    st.out_busy  = out_valid_r && !out_tready;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_W-STAT_W-OFF_W-LVL_W){1'b0}}, out_lvl_r, out_off_r, out_stat_r};

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_valid_r && !out_tready))
    else $error("pending result overwritten");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.res_set && cmd.res_status != ST_OK) |=> (res_off_r == '0 && res_lvl_r == '0))
    else $error("error result carries data");
  a_mark_in_tree: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.mark_set || cmd.mark_clr) |-> waddr != {NODE_W{1'b1}})
    else $error("write beyond tree");

endmodule

// ----- rtl/core/buddy_tree_block_allocator.sv -----
// buddy block allocator top level: controller and datapath
// One transaction at a time. After reset a clearing pass empties the mark store
// before the first request is taken. Every mark lookup is one registered read of
// the mark memory followed by an evaluate state. An allocate visits candidate
// blocks of its level left to right, checking each block itself for a mark, then
// each ancestor up to the root and each node of its subtree. A free walks the tree
// levels from the root down and checks the mark of the block on each level that
// the free offset is aligned to. The result is held in an output register, so a
// new request is taken while it waits.
module buddy_tree_block_allocator (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [bta_pkg::IN_W-1:0]  in_tdata,   // command, request_size, free_offset
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [bta_pkg::OUT_W-1:0] out_tdata   // status, block_offset, block_level
);
  import bta_pkg::*;

  bta_cmd_t  cmd;
  bta_stat_t st;

  bta_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  bta_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .st         (st),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
